// ----- rtl/crros_pkg.sv -----
`timescale 1ns / 1ps

package crros_pkg;

   localparam int RANK_W       = 4;
   localparam int ACTIVE_W     = 5;
   localparam int THREAD_W     = 9;
   localparam int MIN_JOBS_W   = 10;
   localparam int DATA_W       = 16;
   localparam int THRESH_W     = 19;
   localparam int THRESH_FLOOR = 20;
   localparam int CMD_W        = 2;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 10;

   localparam logic [CMD_W-1:0] CMD_SET        = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RELOAD     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_SELECT     = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ_CLEAR = 2'd3;

   localparam logic [CSR_INDEX_W-1:0] CSR_OWN_RANK     = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_ACTIVE_RANKS = 2'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_THREAD_COUNT = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_JOBS     = 2'd3;

   localparam logic [RANK_W-1:0]     OWN_RANK_RST     = 4'd0;
   localparam logic [ACTIVE_W-1:0]   ACTIVE_RANKS_RST = 5'd16;
   localparam logic [THREAD_W-1:0]   THREAD_COUNT_RST = 9'd1;
   localparam logic [MIN_JOBS_W-1:0] MIN_JOBS_RST     = 10'd1;

   typedef struct packed {
      logic [RANK_W-1:0]   own_rank;
      logic [ACTIVE_W-1:0] active_ranks;
      logic [THRESH_W-1:0] threshold;
   } cfg_type;

   typedef struct packed {
      logic quota_we;
      logic credit_we;
      logic skip_we;
   } tbl_we_type;

endpackage

// ----- rtl/crros_req_if.sv -----
`timescale 1ns / 1ps

interface crros_req_if;
   logic                                valid;
   logic                                ready;
   logic [crros_pkg::CMD_W-1:0]         command;
   logic [crros_pkg::RANK_W-1:0]        rank;
   logic signed [crros_pkg::DATA_W-1:0] value;
   logic [crros_pkg::DATA_W-1:0]        waiting_jobs;

   modport source(output valid, command, rank, value, waiting_jobs, input ready);
   modport sink(input valid, command, rank, value, waiting_jobs, output ready);
endinterface

// ----- rtl/crros_rsp_if.sv -----
`timescale 1ns / 1ps

interface crros_rsp_if;
   logic                         valid;
   logic                         ready;
   logic                         offload;
   logic [crros_pkg::RANK_W-1:0] victim_rank;
   logic [crros_pkg::DATA_W-1:0] skip_count;

   modport source(output valid, offload, victim_rank, skip_count, input ready);
   modport sink(input valid, offload, victim_rank, skip_count, output ready);
endinterface

// ----- rtl/crros_csr_if.sv -----
`timescale 1ns / 1ps

interface crros_csr_if;
   logic                              valid;
   logic                              ready;
   logic [crros_pkg::CSR_INDEX_W-1:0] index;
   logic [crros_pkg::CSR_DATA_W-1:0]  data;

   modport source(output valid, index, data, input ready);
   modport sink(input valid, index, data, output ready);
endinterface

// ----- rtl/crros_cfg.sv -----
`timescale 1ns / 1ps

module crros_cfg (
   input  logic               clock,
   input  logic               reset,
   crros_csr_if.sink          csr_ch,
   output crros_pkg::cfg_type cfg
);

   localparam int RW = crros_pkg::RANK_W;
   localparam int AW = crros_pkg::ACTIVE_W;
   localparam int HW = crros_pkg::THREAD_W;
   localparam int MW = crros_pkg::MIN_JOBS_W;
   localparam int TW = crros_pkg::THRESH_W;
   localparam logic [TW-1:0] FLOOR = TW'(crros_pkg::THRESH_FLOOR);

   logic [RW-1:0] own_ff, own_in;
   logic [AW-1:0] active_ff, active_in;
   logic [HW-1:0] thread_ff, thread_in;
   logic [MW-1:0] min_jobs_ff, min_jobs_in;
   logic [TW-1:0] thresh_ff, thresh_in;
   logic [HW-1:0] factor;
   logic [TW-1:0] prod;
   logic [TW-1:0] sum;
   logic          wr;

   assign csr_ch.ready = 1'b1;
   assign wr = csr_ch.valid && csr_ch.ready;

   always_comb begin
      own_in      = own_ff;
      active_in   = active_ff;
      thread_in   = thread_ff;
      min_jobs_in = min_jobs_ff;
      if (wr) begin
         unique case (csr_ch.index)
            crros_pkg::CSR_OWN_RANK:     own_in      = csr_ch.data[RW-1:0];
            crros_pkg::CSR_ACTIVE_RANKS: active_in   = csr_ch.data[AW-1:0];
            crros_pkg::CSR_THREAD_COUNT: thread_in   = csr_ch.data[HW-1:0];
            crros_pkg::CSR_MIN_JOBS:     min_jobs_in = csr_ch.data[MW-1:0];
         endcase
      end
   end

   // threshold = max(1 + max(1, threads - 1) * min_jobs, floor)
   assign factor    = (thread_ff > HW'(1)) ? thread_ff - HW'(1) : HW'(1);
   assign prod      = TW'(factor) * TW'(min_jobs_ff);
   assign sum       = prod + TW'(1);
   assign thresh_in = (sum < FLOOR) ? FLOOR : sum;

   always_ff @(posedge clock) begin
      if (reset) begin
         own_ff      <= crros_pkg::OWN_RANK_RST;
         active_ff   <= crros_pkg::ACTIVE_RANKS_RST;
         thread_ff   <= crros_pkg::THREAD_COUNT_RST;
         min_jobs_ff <= crros_pkg::MIN_JOBS_RST;
         thresh_ff   <= FLOOR;
      end else begin
         own_ff      <= own_in;
         active_ff   <= active_in;
         thread_ff   <= thread_in;
         min_jobs_ff <= min_jobs_in;
         thresh_ff   <= thresh_in;
      end
   end

   always_comb begin
      cfg.own_rank     = own_ff;
      cfg.active_ranks = active_ff;
      cfg.threshold    = thresh_ff;
   end

endmodule

// ----- rtl/crros_tables.sv -----
`timescale 1ns / 1ps

module crros_tables #(
   parameter int MAX_RANKS = 16,
   localparam int IW = $clog2(MAX_RANKS)
) (
   input  logic                         clock,
   input  crros_pkg::tbl_we_type        tbl_we,
   input  logic [IW-1:0]                tbl_waddr,
   input  logic [IW-1:0]                tbl_raddr,
   input  logic [crros_pkg::DATA_W-1:0] tbl_wdata,
   output logic [crros_pkg::DATA_W-1:0] quota_rdata,
   output logic [crros_pkg::DATA_W-1:0] credit_rdata,
   output logic [crros_pkg::DATA_W-1:0] skip_rdata
);

   localparam int DW = crros_pkg::DATA_W;

   logic [DW-1:0] quota_mem  [MAX_RANKS];
   logic [DW-1:0] credit_mem [MAX_RANKS];
   logic [DW-1:0] skip_mem   [MAX_RANKS];
   logic [DW-1:0] quota_rd_ff;
   logic [DW-1:0] credit_rd_ff;
   logic [DW-1:0] skip_rd_ff;

   always_ff @(posedge clock) begin
      if (tbl_we.quota_we) begin
         quota_mem[tbl_waddr] <= tbl_wdata;
      end
      quota_rd_ff <= quota_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we.credit_we) begin
         credit_mem[tbl_waddr] <= tbl_wdata;
      end
      credit_rd_ff <= credit_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (tbl_we.skip_we) begin
         skip_mem[tbl_waddr] <= tbl_wdata;
      end
      skip_rd_ff <= skip_mem[tbl_raddr];
   end

   assign quota_rdata  = quota_rd_ff;
   assign credit_rdata = credit_rd_ff;
   assign skip_rdata   = skip_rd_ff;

endmodule

// ----- rtl/crros_seq.sv -----
`timescale 1ns / 1ps

module crros_seq #(
   parameter int MAX_RANKS = 16,
   localparam int IW = $clog2(MAX_RANKS)
) (
   input  logic                         clock,
   input  logic                         reset,
   input  crros_pkg::cfg_type           cfg,
   crros_req_if.sink                    req_ch,
   crros_rsp_if.source                  rsp_ch,
   output crros_pkg::tbl_we_type        tbl_we,
   output logic [IW-1:0]                tbl_waddr,
   output logic [IW-1:0]                tbl_raddr,
   output logic [crros_pkg::DATA_W-1:0] tbl_wdata,
   input  logic [crros_pkg::DATA_W-1:0] quota_rdata,
   input  logic [crros_pkg::DATA_W-1:0] credit_rdata,
   input  logic [crros_pkg::DATA_W-1:0] skip_rdata
);

   localparam int RW = crros_pkg::RANK_W;
   localparam int DW = crros_pkg::DATA_W;
   localparam int TW = crros_pkg::THRESH_W;
   localparam int NW = ($clog2(MAX_RANKS + 1) > crros_pkg::ACTIVE_W) ?
                       $clog2(MAX_RANKS + 1) : crros_pkg::ACTIVE_W;
   localparam logic [NW-1:0] MAX_NW  = NW'(MAX_RANKS);
   localparam logic [NW-1:0] LAST_NW = NW'(MAX_RANKS - 1);

   localparam logic [3:0] ST_CLEAR     = 4'd0;
   localparam logic [3:0] ST_IDLE      = 4'd1;
   localparam logic [3:0] ST_SET       = 4'd2;
   localparam logic [3:0] ST_RELOAD    = 4'd3;
   localparam logic [3:0] ST_SEL_START = 4'd4;
   localparam logic [3:0] ST_SCAN      = 4'd5;
   localparam logic [3:0] ST_SKIP_RD   = 4'd6;
   localparam logic [3:0] ST_SKIP_WR   = 4'd7;
   localparam logic [3:0] ST_RC_RD     = 4'd8;
   localparam logic [3:0] ST_RC_WR     = 4'd9;
   localparam logic [3:0] ST_DONE      = 4'd10;

   logic [3:0]           state_ff, state_in;
   logic [RW-1:0]        rank_ff, rank_in;
   logic signed [DW-1:0] value_ff, value_in;
   logic [DW-1:0]        waiting_ff, waiting_in;
   logic [NW-1:0]        n_ff, n_in;
   logic [NW-1:0]        cnt_ff, cnt_in;
   logic [IW-1:0]        p_ff, p_in;
   logic [IW-1:0]        rr_ff, rr_in;
   logic [IW-1:0]        pick_ff, pick_in;
   logic                 found_ff, found_in;
   logic                 wr_pend_ff, wr_pend_in;
   logic                 res_offload_ff, res_offload_in;
   logic [RW-1:0]        res_victim_ff, res_victim_in;
   logic [DW-1:0]        res_skip_ff, res_skip_in;
   logic                 rsp_vld_ff, rsp_vld_in;
   logic                 rsp_offload_ff, rsp_offload_in;
   logic [RW-1:0]        rsp_victim_ff, rsp_victim_in;
   logic [DW-1:0]        rsp_skip_ff, rsp_skip_in;

   logic          accept;
   logic          rsp_free;
   logic [NW-1:0] act_nw;
   logic [NW-1:0] n_calc;
   logic [NW-1:0] own_nw;
   logic [NW-1:0] rank_nw;
   logic [NW-1:0] p_nw;
   logic [NW-1:0] pick_nw;
   logic [NW-1:0] p_next_nw;
   logic [NW-1:0] target_nw;
   logic [IW-1:0] nxt_p;
   logic [IW-1:0] p_start;
   logic          hit;
   logic          cancel;

   assign req_ch.ready = (state_ff == ST_IDLE);
   assign accept       = req_ch.valid && req_ch.ready;
   assign rsp_free     = !rsp_vld_ff || rsp_ch.ready;

   assign act_nw  = NW'(cfg.active_ranks);
   assign n_calc  = (act_nw == '0) ? NW'(1) : ((act_nw > MAX_NW) ? MAX_NW : act_nw);
   assign own_nw  = NW'(cfg.own_rank);
   assign rank_nw = NW'(rank_ff);
   assign p_nw    = NW'(p_ff);
   assign pick_nw = NW'(pick_ff);

   assign p_next_nw = p_nw + NW'(1);
   assign nxt_p     = (p_next_nw == n_ff) ? '0 : p_next_nw[IW-1:0];
   assign p_start   = (NW'(rr_ff) < n_ff) ? rr_ff : '0;

   // credit test of the scan unit: remote target with positive credit
   assign hit       = (p_nw != own_nw) && ($signed(credit_rdata) > 0);
   assign cancel    = TW'(waiting_ff) < cfg.threshold;
   assign target_nw = found_ff ? pick_nw : own_nw;

   always_comb begin
      state_in       = state_ff;
      rank_in        = rank_ff;
      value_in       = value_ff;
      waiting_in     = waiting_ff;
      n_in           = n_ff;
      cnt_in         = cnt_ff;
      p_in           = p_ff;
      rr_in          = rr_ff;
      pick_in        = pick_ff;
      found_in       = found_ff;
      wr_pend_in     = wr_pend_ff;
      res_offload_in = res_offload_ff;
      res_victim_in  = res_victim_ff;
      res_skip_in    = res_skip_ff;
      rsp_vld_in     = rsp_vld_ff && !rsp_ch.ready;
      rsp_offload_in = rsp_offload_ff;
      rsp_victim_in  = rsp_victim_ff;
      rsp_skip_in    = rsp_skip_ff;
      tbl_we         = '0;
      tbl_waddr      = p_ff;
      tbl_raddr      = p_ff;
      tbl_wdata      = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            tbl_we    = '{quota_we: 1'b1, credit_we: 1'b1, skip_we: 1'b1};
            tbl_waddr = cnt_ff[IW-1:0];
            if (cnt_ff == LAST_NW) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end else begin
               cnt_in = cnt_ff + NW'(1);
            end
         end
         ST_IDLE: begin
            if (accept) begin
               rank_in    = req_ch.rank;
               value_in   = req_ch.value;
               waiting_in = req_ch.waiting_jobs;
               n_in       = n_calc;
               cnt_in     = '0;
               wr_pend_in = 1'b0;
               found_in   = 1'b0;
               unique case (req_ch.command)
                  crros_pkg::CMD_SET:        state_in = ST_SET;
                  crros_pkg::CMD_RELOAD:     state_in = ST_RELOAD;
                  crros_pkg::CMD_SELECT:     state_in = ST_SEL_START;
                  crros_pkg::CMD_READ_CLEAR: state_in = ST_RC_RD;
               endcase
            end
         end
         ST_SET: begin
            if (rank_nw < MAX_NW) begin
               tbl_we.quota_we = 1'b1;
               tbl_waddr       = rank_nw[IW-1:0];
            end
            tbl_wdata      = value_ff;
            res_offload_in = 1'b0;
            res_victim_in  = cfg.own_rank;
            res_skip_in    = '0;
            state_in       = ST_DONE;
         end
         ST_RELOAD: begin
            // read quota at cnt, write credit one entry behind
            if (wr_pend_ff && (p_nw != own_nw)) begin
               tbl_we.credit_we = 1'b1;
               tbl_waddr        = p_ff;
               tbl_wdata        = quota_rdata;
            end
            if (cnt_ff < n_ff) begin
               tbl_raddr  = cnt_ff[IW-1:0];
               p_in       = cnt_ff[IW-1:0];
               wr_pend_in = 1'b1;
               cnt_in     = cnt_ff + NW'(1);
            end else begin
               wr_pend_in = 1'b0;
               if (!wr_pend_ff) begin
                  res_offload_in = 1'b0;
                  res_victim_in  = cfg.own_rank;
                  res_skip_in    = '0;
                  state_in       = ST_DONE;
               end
            end
         end
         ST_SEL_START: begin
            tbl_raddr = p_start;
            p_in      = p_start;
            state_in  = ST_SCAN;
         end
         ST_SCAN: begin
            // next entry is read ahead while this one is charged or cleared
            tbl_raddr        = nxt_p;
            tbl_we.credit_we = 1'b1;
            tbl_waddr        = p_ff;
            if (hit) begin
               tbl_wdata = credit_rdata - DW'(1);
               pick_in   = p_ff;
               found_in  = 1'b1;
               rr_in     = nxt_p;
               state_in  = ST_SKIP_RD;
            end else begin
               tbl_wdata = '0;
               p_in      = nxt_p;
               cnt_in    = cnt_ff + NW'(1);
               if (cnt_ff + NW'(1) == n_ff) begin
                  rr_in    = nxt_p;
                  state_in = ST_SKIP_RD;
               end
            end
         end
         ST_SKIP_RD: begin
            tbl_raddr   = target_nw[IW-1:0];
            res_skip_in = '0;
            if (cancel) begin
               res_offload_in = 1'b0;
               res_victim_in  = cfg.own_rank;
               if (target_nw < MAX_NW) begin
                  p_in     = target_nw[IW-1:0];
                  state_in = ST_SKIP_WR;
               end else begin
                  state_in = ST_DONE;
               end
            end else begin
               res_offload_in = found_ff;
               res_victim_in  = found_ff ? pick_nw[RW-1:0] : cfg.own_rank;
               state_in       = ST_DONE;
            end
         end
         ST_SKIP_WR: begin
            tbl_we.skip_we = 1'b1;
            tbl_waddr      = p_ff;
            tbl_wdata      = (skip_rdata == '1) ? skip_rdata : skip_rdata + DW'(1);
            state_in       = ST_DONE;
         end
         ST_RC_RD: begin
            tbl_raddr      = rank_nw[IW-1:0];
            res_offload_in = 1'b0;
            res_victim_in  = cfg.own_rank;
            res_skip_in    = '0;
            state_in       = (rank_nw < MAX_NW) ? ST_RC_WR : ST_DONE;
         end
         ST_RC_WR: begin
            tbl_we.skip_we = 1'b1;
            tbl_waddr      = rank_nw[IW-1:0];
            tbl_wdata      = '0;
            res_skip_in    = skip_rdata;
            state_in       = ST_DONE;
         end
         ST_DONE: begin
            if (rsp_free) begin
               rsp_vld_in     = 1'b1;
               rsp_offload_in = res_offload_ff;
               rsp_victim_in  = res_victim_ff;
               rsp_skip_in    = res_skip_ff;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_CLEAR;
         cnt_ff     <= '0;
         rr_ff      <= '0;
         found_ff   <= 1'b0;
         wr_pend_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         rr_ff      <= rr_in;
         found_ff   <= found_in;
         wr_pend_ff <= wr_pend_in;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff        <= rank_in;
      value_ff       <= value_in;
      waiting_ff     <= waiting_in;
      n_ff           <= n_in;
      p_ff           <= p_in;
      pick_ff        <= pick_in;
      res_offload_ff <= res_offload_in;
      res_victim_ff  <= res_victim_in;
      res_skip_ff    <= res_skip_in;
      rsp_offload_ff <= rsp_offload_in;
      rsp_victim_ff  <= rsp_victim_in;
      rsp_skip_ff    <= rsp_skip_in;
   end

   assign rsp_ch.valid       = rsp_vld_ff;
   assign rsp_ch.offload     = rsp_offload_ff;
   assign rsp_ch.victim_rank = rsp_victim_ff;
   assign rsp_ch.skip_count  = rsp_skip_ff;

endmodule

// ----- rtl/credit_round_robin_offload_selector_top.sv -----
`timescale 1ns / 1ps

// Credit-based round-robin offload target selector. Each request item carries one command:
// set a target's quota, reload the remote targets' credits from the quotas, select a target, or read and
// clear a target's skip counter; every item gives exactly one response item. The quota,
// credit and skip tables are single-write, registered-read memories of MAX_RANKS entries.
// After reset a clearing pass writes zero to all three tables, one entry per cycle, during
// which no request item is accepted; configuration writes are taken at any time. One item
// is worked on at a time, and each command ends by handing its result to the output
// register: set writes the quota, read-clear reads and then clears the skip counter, reload
// copies the quotas into the remote credits, and select scans the credits and may then bump
// a skip counter. The scan and reload loops handle one table entry per cycle through the
// tables' one read port, the scan also through the credit compare and decrement unit. The
// next item is accepted while a finished response still waits in the output register.
module credit_round_robin_offload_selector_top #(
   parameter int MAX_RANKS = 16
) (
   input  logic          clock,
   input  logic          reset,
   crros_req_if.sink     req_ch,
   crros_rsp_if.source   rsp_ch,
   crros_csr_if.sink     csr_ch
);

   localparam int IW = $clog2(MAX_RANKS);
   localparam int DW = crros_pkg::DATA_W;

   crros_pkg::cfg_type    cfg;
   crros_pkg::tbl_we_type tbl_we;
   logic [IW-1:0]         tbl_waddr;
   logic [IW-1:0]         tbl_raddr;
   logic [DW-1:0]         tbl_wdata;
   logic [DW-1:0]         quota_rdata;
   logic [DW-1:0]         credit_rdata;
   logic [DW-1:0]         skip_rdata;

   crros_cfg u_cfg (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   crros_tables #(
      .MAX_RANKS (MAX_RANKS)
   ) u_tables (
      .clock        (clock),
      .tbl_we       (tbl_we),
      .tbl_waddr    (tbl_waddr),
      .tbl_raddr    (tbl_raddr),
      .tbl_wdata    (tbl_wdata),
      .quota_rdata  (quota_rdata),
      .credit_rdata (credit_rdata),
      .skip_rdata   (skip_rdata)
   );

   crros_seq #(
      .MAX_RANKS (MAX_RANKS)
   ) u_seq (
      .clock        (clock),
      .reset        (reset),
      .cfg          (cfg),
      .req_ch       (req_ch),
      .rsp_ch       (rsp_ch),
      .tbl_we       (tbl_we),
      .tbl_waddr    (tbl_waddr),
      .tbl_raddr    (tbl_raddr),
      .tbl_wdata    (tbl_wdata),
      .quota_rdata  (quota_rdata),
      .credit_rdata (credit_rdata),
      .skip_rdata   (skip_rdata)
   );

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_ch.valid && req_ch.ready |=> !req_ch.ready)
      else $error("request accepted while an item is in progress");

   a_clear_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !req_ch.ready)
      else $error("request taken before table clear");

   a_offload_no_skip: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.offload |-> rsp_ch.skip_count == '0)
      else $error("offload response carries a skip count");

   a_no_write_collision: assert property (@(posedge clock) disable iff (reset)
      tbl_we.credit_we |-> !tbl_we.skip_we || tbl_we.quota_we)
      else $error("credit and skip written outside the clear pass");

endmodule
